[design/pwms_pkg.sv]
// Package for the PSSM window max scan core: types, codes and default constants.
// It has no dependencies. The controller, the datapath and the top level import it.
package pwms_pkg;

    // Default sizing. The top level exposes these as parameters.
    localparam int DEF_MAX_MOTIF_LEN = 32;
    localparam int DEF_SCORE_BITS    = 16;

    // Fixed field widths.
    localparam int POS_W     = 5;
    localparam int BASE_W    = 2;
    localparam int MLEN_W    = 6;
    localparam int HIT_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_BASES = 4;

    // Register values after reset.
    localparam int MLEN_RESET  = 8;
    localparam int FLOOR_RESET = -25600;

    // Request kinds on the input channel.
    typedef enum logic [0:0] {
        REQ_TABLE = 1'b0,
        REQ_BASE  = 1'b1
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTIF_LEN = 1'b0,
        CFG_FLOOR     = 1'b1
    } t_cfg_idx;

    // Controller states. They track the result slot.
    typedef enum logic [1:0] {
        ST_OPEN,
        ST_SCORE,
        ST_SHOW
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic table_wr;
        logic step;
        logic last_step;
        logic finish;
    } t_cmd;

endpackage

[design/pwms_ctrl.sv]
// Controller for the PSSM window max scan core: the handshake and the result slot.
// It depends on pwms_pkg and drives the command struct that the datapath consumes.
module pwms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_last,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output pwms_pkg::t_cmd o_cmd
);
    import pwms_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_base;

    assign accept  = i_in_valid && o_in_ready;
    assign is_base = (t_req'(i_req_type) == REQ_BASE);

    // The state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_OPEN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. A last base moves the block to scoring, then to showing the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_OPEN: begin
                if (accept && is_base && i_last) n_state = ST_SCORE;
            end
            ST_SCORE: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (accept && is_base && i_last) begin
                    n_state = ST_SCORE;
                end else if (i_out_ready) begin
                    n_state = ST_OPEN;
                end
            end
            default: n_state = ST_OPEN;
        endcase
    end

    // Outputs. In the show state only a last base waits for the result to drain.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_OPEN:  o_in_ready = 1'b1;
            ST_SCORE: o_in_ready = 1'b0;
            ST_SHOW: begin
                o_in_ready  = i_out_ready || !(is_base && i_last);
                o_out_valid = 1'b1;
            end
            default: o_in_ready = 1'b0;
        endcase
        o_cmd.table_wr  = accept && !is_base;
        o_cmd.step      = accept && is_base;
        o_cmd.last_step = accept && is_base && i_last;
        o_cmd.finish    = (r_state == ST_SCORE);
    end

    // The final scoring cycle always leads to a shown result.
    a_score_to_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCORE |=> r_state == ST_SHOW)
        else $error("scoring cycle not followed by result");

    // A last base always enters the final scoring cycle.
    a_last_scores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.last_step |=> r_state == ST_SCORE)
        else $error("last base did not start final scoring");

    // A waiting result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

endmodule

[design/pwms_datapath.sv]
// Datapath for the PSSM window max scan core: score cells, window select, best tracking.
// It depends on pwms_pkg and acts on the commands from pwms_ctrl.
module pwms_datapath #(
    parameter int MAX_MOTIF_LEN = pwms_pkg::DEF_MAX_MOTIF_LEN,
    parameter int SCORE_BITS    = pwms_pkg::DEF_SCORE_BITS,
    parameter int SUM_BITS      = SCORE_BITS + $clog2(MAX_MOTIF_LEN)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pwms_pkg::t_cmd                      i_cmd,
    input  logic [pwms_pkg::BASE_W-1:0]         i_base,
    input  logic [pwms_pkg::POS_W-1:0]          i_position,
    input  logic signed [SCORE_BITS-1:0]        i_score,
    input  logic                                i_cfg_wr,
    input  logic [pwms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SUM_BITS-1:0]                 i_cfg_data,
    output logic signed [SUM_BITS-1:0]          o_max_score,
    output logic [pwms_pkg::HIT_W-1:0]          o_hit_count
);
    import pwms_pkg::*;

    localparam int IDX_W = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_MOTIF_LEN + 1);
    localparam int CMP_W = 7;

    // Configuration registers.
    logic [MLEN_W-1:0]          r_motif_len;
    logic signed [SUM_BITS-1:0] r_floor;

    // Score cells: per position four table entries and one partial sum.
    logic signed [SCORE_BITS-1:0] r_tab  [MAX_MOTIF_LEN][NUM_BASES];
    logic signed [SUM_BITS-1:0]   r_psum [MAX_MOTIF_LEN];
    logic signed [SUM_BITS-1:0]   n_psum [MAX_MOTIF_LEN];
    logic [CNT_W-1:0]             r_bases;
    logic [CNT_W-1:0]             n_bases;

    // Window stage and best tracking.
    logic [IDX_W-1:0]           win_idx;
    logic                       r_s2_valid;
    logic                       r_s2_ok;
    logic signed [SUM_BITS-1:0] r_s2_win;
    logic signed [SUM_BITS-1:0] r_best;
    logic signed [SUM_BITS-1:0] n_best;
    logic [HIT_W-1:0]           r_tie;
    logic [HIT_W-1:0]           n_tie;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_len <= MLEN_W'(MLEN_RESET);
            r_floor     <= SUM_BITS'(FLOOR_RESET);
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MOTIF_LEN: r_motif_len <= i_cfg_data[MLEN_W-1:0];
                CFG_FLOOR:     r_floor     <= i_cfg_data;
            endcase
        end
    end

    // Each cell adds its own entry for the incoming base to its neighbor's sum.
    for (genvar p = 0; p < MAX_MOTIF_LEN; p++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.table_wr && (int'(i_position) == p)) begin
                r_tab[p][i_base] <= i_score;
            end
        end
        if (p == 0) begin : g_first
            assign n_psum[p] = SUM_BITS'(r_tab[p][i_base]);
        end else begin : g_rest
            assign n_psum[p] = r_psum[p-1] + SUM_BITS'(r_tab[p][i_base]);
        end
    end

    // Window end index, with the motif length clamped to the cell count.
    always_comb begin
        if (r_motif_len == '0) begin
            win_idx = '0;
        end else if (CMP_W'(r_motif_len) > CMP_W'(MAX_MOTIF_LEN)) begin
            win_idx = IDX_W'(MAX_MOTIF_LEN - 1);
        end else begin
            win_idx = IDX_W'(r_motif_len - MLEN_W'(1));
        end
        n_bases = (r_bases == CNT_W'(MAX_MOTIF_LEN)) ? r_bases : r_bases + CNT_W'(1);
    end

    // Stage one: shift the partial sums and register the window sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases    <= '0;
            r_s2_valid <= 1'b0;
            for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
                r_psum[i] <= '0;
            end
        end else begin
            r_s2_valid <= i_cmd.step;
            if (i_cmd.step) begin
                r_bases <= i_cmd.last_step ? '0 : n_bases;
                for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
                    r_psum[i] <= i_cmd.last_step ? '0 : n_psum[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_s2_ok  <= CMP_W'(n_bases) > CMP_W'(win_idx);
            r_s2_win <= n_psum[win_idx];
        end
    end

    // Stage two: compare the window with the best so far and count ties.
    always_comb begin
        n_best = r_best;
        n_tie  = r_tie;
        if (r_s2_valid && r_s2_ok) begin
            if (r_s2_win > r_best) begin
                n_best = r_s2_win;
                n_tie  = HIT_W'(1);
            end else if ((r_s2_win == r_best) && (r_tie != '1)) begin
                n_tie = r_tie + HIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= SUM_BITS'(FLOOR_RESET);
            r_tie  <= '0;
        end else if (i_cmd.finish) begin
            r_best <= r_floor;
            r_tie  <= '0;
        end else begin
            r_best <= n_best;
            r_tie  <= n_tie;
        end
    end

    // Result register, loaded when the last window has been scored.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_max_score <= n_best;
            o_hit_count <= n_tie;
        end
    end

    // The end of a sequence clears the window state.
    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.last_step |=> (r_bases == '0) && (r_psum[0] == '0))
        else $error("sequence state not cleared after last base");

    // A new best restarts the tie count at one.
    a_new_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_ok && (r_s2_win > r_best) && !i_cmd.finish
        |=> (r_tie == HIT_W'(1)) && (r_best == $past(r_s2_win)))
        else $error("new best score not taken");

    // The final scoring cycle always follows a scored base.
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_s2_valid)
        else $error("final scoring without a base in flight");

endmodule

[design/pssm_window_max_scan_core.sv]
// Top level of the PSSM window max scan core.
// It depends on pwms_pkg and instantiates pwms_ctrl and pwms_datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request per item: a
//   table write (position, base, score) or a sequence base with a last flag.
//   Output channel (o_out_valid / i_out_ready) carries one result per sequence:
//   the best window score and the number of windows that tie it.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the motif length
//   (index 0) and the floor score (index 1). It is always ready.
// Timing:
//   One request is taken per cycle while the input is ready. A base marked
//   last has its result built as follows: the edge that takes it updates the
//   partial-sum cells and registers the window sum, and the scoring state
//   then compares it against the best score and loads the result. The input
//   is not ready in the cycle after a last base.
// Reset and stalls:
//   Reset clears the sums, counts and result slot and loads the register
//   defaults; the score table keeps undefined contents until written. While a
//   result waits, table writes and bases not marked last still flow; a base
//   marked last waits for the output slot, which frees in the cycle that
//   i_out_ready is seen.
module pssm_window_max_scan_core #(
    parameter int MAX_MOTIF_LEN = pwms_pkg::DEF_MAX_MOTIF_LEN,
    parameter int SCORE_BITS    = pwms_pkg::DEF_SCORE_BITS,
    parameter int SUM_BITS      = SCORE_BITS + $clog2(MAX_MOTIF_LEN)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [pwms_pkg::BASE_W-1:0]    i_base,
    input  logic [pwms_pkg::POS_W-1:0]     i_position,
    input  logic signed [SCORE_BITS-1:0]   i_score,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SUM_BITS-1:0]     o_max_score,
    output logic [pwms_pkg::HIT_W-1:0]     o_hit_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SUM_BITS-1:0]            i_cfg_data
);
    import pwms_pkg::*;

    t_cmd cmd;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Handshake and result slot control.
    pwms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Score cells and best tracking.
    pwms_datapath #(
        .MAX_MOTIF_LEN (MAX_MOTIF_LEN),
        .SCORE_BITS    (SCORE_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_base      (i_base),
        .i_position  (i_position),
        .i_score     (i_score),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_max_score (o_max_score),
        .o_hit_count (o_hit_count)
    );

endmodule
